// ----- hdl/hsvadj_pkg.sv -----
package hsvadj_pkg;

	// Fixed-point units: one hue sector and unity saturation/value are both 2^16.
	localparam int FRAC_W   = 16;
	localparam int Q_W      = FRAC_W + 1;
	localparam int DIV_W    = 8;
	localparam int REM_W    = DIV_W + 1;
	localparam int N_CELLS  = Q_W;

	// Configuration register indexes.
	localparam logic [2:0] REG_HUE_SHIFT    = 3'd0;
	localparam logic [2:0] REG_SAT_ADJUST   = 3'd1;
	localparam logic [2:0] REG_SAT_ADDITIVE = 3'd2;
	localparam logic [2:0] REG_VAL_ADJUST   = 3'd3;
	localparam logic [2:0] REG_VAL_ADDITIVE = 3'd4;

	// Channel that holds the maximum, which picks the hue base sector.
	typedef enum logic [1:0] {
		HB_RED,
		HB_GREEN,
		HB_BLUE
	} hbase_t;

	// One lane of the long division: partial remainder, divisor, quotient so far.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DIV_W-1:0] dvs;
		logic [Q_W-1:0]   quo;
	} div_lane_t;

	// Per-pixel side information that rides along the divider chain.
	typedef struct packed {
		logic [23:0] rgb;
		logic        pass;
		logic        neg;
		logic        hzero;
		hbase_t      base;
		logic [7:0]  mx;
	} side_t;

endpackage

// ----- hdl/hsvadj_div_cell.sv -----
module hsvadj_div_cell
	import hsvadj_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_in,
	input  div_lane_t hue_in,
	input  div_lane_t sat_in,
	input  side_t     side_in,
	output logic      vld_out,
	output div_lane_t hue_out,
	output div_lane_t sat_out,
	output side_t     side_out
);

	div_lane_t hue_nxt;
	div_lane_t sat_nxt;
	logic      hue_ge;
	logic      sat_ge;
	logic [REM_W-1:0] hue_t;
	logic [REM_W-1:0] sat_t;

	// One restoring division step per lane; the remainder leaves already doubled.
	always_comb begin
		hue_ge = hue_in.rem >= {1'b0, hue_in.dvs};
		hue_t  = hue_ge ? hue_in.rem - {1'b0, hue_in.dvs} : hue_in.rem;
		hue_nxt.rem = {hue_t[DIV_W-1:0], 1'b0};
		hue_nxt.dvs = hue_in.dvs;
		hue_nxt.quo = {hue_in.quo[Q_W-2:0], hue_ge};

		sat_ge = sat_in.rem >= {1'b0, sat_in.dvs};
		sat_t  = sat_ge ? sat_in.rem - {1'b0, sat_in.dvs} : sat_in.rem;
		sat_nxt.rem = {sat_t[DIV_W-1:0], 1'b0};
		sat_nxt.dvs = sat_in.dvs;
		sat_nxt.quo = {sat_in.quo[Q_W-2:0], sat_ge};
	end

	// Valid flag is control state; the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_out  <= hue_nxt;
			sat_out  <= sat_nxt;
			side_out <= side_in;
		end
	end

endmodule

// ----- hdl/pixel_hsv_adjust.sv -----
// Adjusts hue, saturation and value of an 8-bit RGB pixel stream. One pixel is
// accepted per clock cycle while s_tready is high; each pixel passes the row of
// 17 divider cells (one quotient bit each) that forms hue and saturation, plus
// six arithmetic stages around it. The whole pipeline advances when the output
// register is empty or its result is being taken. Configuration registers are
// to be written through cfg_we/cfg_index/cfg_data only while the stream is idle,
// which the block does not enforce; a hue shift goes to hue_shift_q, then shift_q.
module pixel_hsv_adjust
	import hsvadj_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic signed [22:0] UNIT_X2  = 23'sd131072;
	localparam logic signed [22:0] UNIT_X4  = 23'sd262144;
	localparam logic signed [22:0] FULL     = 23'sd393216;
	localparam logic signed [22:0] FULL_X2  = 23'sd786432;
	localparam logic [16:0]        ONE      = 17'd65536;
	localparam logic [10:0]        HS_BIAS  = 11'd600;
	localparam logic signed [22:0] SH_BIAS  = 23'sd655360;

	// Configuration registers.
	logic [9:0]  hue_shift_q;
	logic [15:0] sat_adjust_q;
	logic        sat_additive_q;
	logic [15:0] val_adjust_q;
	logic        val_additive_q;
	logic signed [22:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q    <= '0;
			sat_adjust_q   <= '0;
			sat_additive_q <= 1'b0;
			val_adjust_q   <= '0;
			val_additive_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HUE_SHIFT:    hue_shift_q    <= cfg_data[9:0];
				REG_SAT_ADJUST:   sat_adjust_q   <= cfg_data;
				REG_SAT_ADDITIVE: sat_additive_q <= cfg_data[0];
				REG_VAL_ADJUST:   val_adjust_q   <= cfg_data;
				REG_VAL_ADDITIVE: val_additive_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hue shift in sector units: floor(deg*65536/60) = floor(deg*16384/15).
	// The degree value is biased positive by 600 = 15*40 so the floor is plain.
	logic [10:0] hs_x;
	logic [12:0] hs_y;
	logic [25:0] hs_prod;
	logic [20:0] hs_pos;

	always_comb begin
		hs_x    = 11'(signed'(hue_shift_q)) + HS_BIAS;
		hs_y    = {hs_x, 2'b00};
		hs_prod = 26'(hs_y) * 26'd4370;
		hs_pos  = 21'(hs_x * 21'd1092) + 21'(hs_prod[25:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else begin
			shift_q <= signed'({2'b00, hs_pos}) - SH_BIAS;
		end
	end

	// The pipeline moves as a whole when the output register can take a result.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: max, min and the dividends for hue and saturation.
	logic [7:0] r_in, g_in, b_in, mx, mn, a_abs;
	logic       neg;
	hbase_t     base;
	logic       vld_s1;
	div_lane_t  hue_s1, sat_s1;
	side_t      side_s1;

	always_comb begin
		r_in = s_tdata[7:0];
		g_in = s_tdata[15:8];
		b_in = s_tdata[23:16];
		mx = (r_in > g_in) ? r_in : g_in;
		if (b_in > mx) mx = b_in;
		mn = (r_in < g_in) ? r_in : g_in;
		if (b_in < mn) mn = b_in;
		if (mx == r_in) begin
			base  = HB_RED;
			neg   = g_in < b_in;
			a_abs = neg ? b_in - g_in : g_in - b_in;
		end else if (mx == g_in) begin
			base  = HB_GREEN;
			neg   = b_in < r_in;
			a_abs = neg ? r_in - b_in : b_in - r_in;
		end else begin
			base  = HB_BLUE;
			neg   = r_in < g_in;
			a_abs = neg ? g_in - r_in : r_in - g_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1.rem    <= {1'b0, a_abs};
			hue_s1.dvs    <= mx - mn;
			hue_s1.quo    <= '0;
			sat_s1.rem    <= {1'b0, mx - mn};
			sat_s1.dvs    <= mx;
			sat_s1.quo    <= '0;
			side_s1.rgb   <= s_tdata;
			side_s1.pass  <= (hue_shift_q == '0) && (sat_adjust_q == '0)
				&& (val_adjust_q == '0);
			side_s1.neg   <= neg;
			side_s1.hzero <= (mx == mn);
			side_s1.base  <= base;
			side_s1.mx    <= mx;
		end
	end

	// Row of divider cells, one quotient bit per cell, most significant first.
	logic      vld_c  [N_CELLS+1];
	div_lane_t hue_c  [N_CELLS+1];
	div_lane_t sat_c  [N_CELLS+1];
	side_t     side_c [N_CELLS+1];

	assign vld_c[0]  = vld_s1;
	assign hue_c[0]  = hue_s1;
	assign sat_c[0]  = sat_s1;
	assign side_c[0] = side_s1;

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		hsvadj_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld_c[i]),
			.hue_in   (hue_c[i]),
			.sat_in   (sat_c[i]),
			.side_in  (side_c[i]),
			.vld_out  (vld_c[i+1]),
			.hue_out  (hue_c[i+1]),
			.sat_out  (sat_c[i+1]),
			.side_out (side_c[i+1])
		);
	end

	// Stage 2: signed floor hue in sector units, saturation and value.
	div_lane_t hq, sq;
	side_t     sd;
	logic [20:0] mag;
	logic signed [22:0] h_raw;
	logic [16:0] v_raw;

	always_comb begin
		hq  = hue_c[N_CELLS];
		sq  = sat_c[N_CELLS];
		sd  = side_c[N_CELLS];
		mag = 21'(hq.quo) + 21'(hq.rem != '0 && sd.neg);
		h_raw = sd.neg ? -signed'({2'b00, mag}) : signed'({2'b00, mag});
		case (sd.base)
			HB_RED:   h_raw = sd.neg ? h_raw + FULL : h_raw;
			HB_GREEN: h_raw = h_raw + UNIT_X2;
			HB_BLUE:  h_raw = h_raw + UNIT_X4;
			default:  h_raw = h_raw;
		endcase
		if (sd.hzero) h_raw = '0;
		v_raw = 17'({sd.mx, sd.mx}) + 17'(sd.mx == 8'hFF);
	end

	logic        vld_s2;
	logic signed [22:0] h_s2;
	logic [16:0] s_s2, v_s2;
	logic [23:0] rgb_s2;
	logic        pass_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_c[N_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s2    <= h_raw;
			s_s2    <= (sd.mx == '0) ? '0 : sq.quo;
			v_s2    <= v_raw;
			rgb_s2  <= sd.rgb;
			pass_s2 <= sd.pass;
		end
	end

	// Multiply by a Q2.14 factor or add a Q2.14 offset, then clamp to 0..1.
	function automatic logic [16:0] adjust(input logic [16:0] x, input logic [15:0] adj,
		input logic additive);
		logic signed [33:0] prod;
		logic signed [33:0] res;
		begin
			prod = signed'({17'b0, x}) * 34'(signed'(adj));
			if (additive) begin
				res = signed'({17'b0, x}) + (34'(signed'(adj)) <<< 2);
			end else begin
				res = prod >>> 14;
			end
			if (res < 0) begin
				adjust = '0;
			end else if (res > signed'({17'b0, ONE})) begin
				adjust = ONE;
			end else begin
				adjust = res[16:0];
			end
		end
	endfunction

	// Stage 3: hue shift with wraparound, saturation and value adjustment.
	logic signed [22:0] h_sum, h_wrap;

	always_comb begin
		h_sum = h_s2 + shift_q;
		if (h_sum >= FULL_X2) begin
			h_wrap = h_sum - FULL_X2;
		end else if (h_sum >= FULL) begin
			h_wrap = h_sum - FULL;
		end else if (h_sum >= 0) begin
			h_wrap = h_sum;
		end else if (h_sum >= -FULL) begin
			h_wrap = h_sum + FULL;
		end else begin
			h_wrap = h_sum + FULL_X2;
		end
	end

	logic        vld_s3;
	logic [2:0]  k_s3;
	logic [15:0] f_s3;
	logic [16:0] s_s3, v_s3;
	logic [23:0] rgb_s3;
	logic        pass_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s3    <= h_wrap[18:16];
			f_s3    <= h_wrap[15:0];
			s_s3    <= adjust(s_s2, sat_adjust_q, sat_additive_q);
			v_s3    <= adjust(v_s2, val_adjust_q, val_additive_q);
			rgb_s3  <= rgb_s2;
			pass_s3 <= pass_s2;
		end
	end

	// Stage 4: p and the two saturation-times-fraction terms.
	logic [33:0] p_prod;
	logic [32:0] sf_prod, sfc_prod;

	always_comb begin
		p_prod   = 34'(v_s3) * 34'(ONE - s_s3);
		sf_prod  = 33'(s_s3) * 33'(f_s3);
		sfc_prod = 33'(s_s3) * 33'(ONE - 17'(f_s3));
	end

	logic        vld_s4;
	logic [2:0]  k_s4;
	logic [16:0] v_s4, p_s4, sf_s4, sfc_s4;
	logic [23:0] rgb_s4;
	logic        pass_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s4    <= k_s3;
			v_s4    <= v_s3;
			p_s4    <= p_prod[32:16];
			sf_s4   <= sf_prod[32:16];
			sfc_s4  <= sfc_prod[32:16];
			rgb_s4  <= rgb_s3;
			pass_s4 <= pass_s3;
		end
	end

	// Stage 5: q and t.
	logic [33:0] q_prod, t_prod;

	always_comb begin
		q_prod = 34'(v_s4) * 34'(ONE - sf_s4);
		t_prod = 34'(v_s4) * 34'(ONE - sfc_s4);
	end

	logic        vld_s5;
	logic [2:0]  k_s5;
	logic [16:0] v_s5, p_s5, q_s5, t_s5;
	logic [23:0] rgb_s5;
	logic        pass_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s5    <= k_s4;
			v_s5    <= v_s4;
			p_s5    <= p_s4;
			q_s5    <= q_prod[32:16];
			t_s5    <= t_prod[32:16];
			rgb_s5  <= rgb_s4;
			pass_s5 <= pass_s4;
		end
	end

	// Scale a unit value to 8 bits: floor(x*255/65536).
	function automatic logic [7:0] to8(input logic [16:0] x);
		logic [24:0] m;
		begin
			m   = {x, 8'b0} - 25'(x);
			to8 = m[23:16];
		end
	endfunction

	// Stage 6: sector selection into the output register.
	logic [16:0] ro, go, bo;

	always_comb begin
		case (k_s5)
			3'd0:    begin ro = v_s5; go = t_s5; bo = p_s5; end
			3'd1:    begin ro = q_s5; go = v_s5; bo = p_s5; end
			3'd2:    begin ro = p_s5; go = v_s5; bo = t_s5; end
			3'd3:    begin ro = p_s5; go = q_s5; bo = v_s5; end
			3'd4:    begin ro = t_s5; go = p_s5; bo = v_s5; end
			default: begin ro = v_s5; go = p_s5; bo = q_s5; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= pass_s5 ? rgb_s5 : {to8(bo), to8(go), to8(ro)};
		end
	end

endmodule
